>>> design/quadrature_pulse_decoder_stats_top_macros.svh
// assertion macros for the quadrature pulse decoder
`ifndef QUADRATURE_PULSE_DECODER_STATS_TOP_MACROS_SVH
`define QUADRATURE_PULSE_DECODER_STATS_TOP_MACROS_SVH
// implication checked every clock outside reset
`define QPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("violation");
// next-cycle implication
`define QPD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("violation");
`endif

>>> design/qpd_pkg.sv
// ----------------------------------------------------------------------
// qpd_pkg
// types and codes shared by the decoder modules
// ----------------------------------------------------------------------
package qpd_pkg;
	typedef enum logic [2:0] {
		CLS_ACCEPTED = 3'd0,
		CLS_NOT_COUNTED = 3'd1,
		CLS_DEBOUNCED = 3'd2,
		CLS_INVALID = 3'd3,
		CLS_IDLE = 3'd4
	} cls_t;

	localparam logic [1:0] DIR_UNKNOWN = 2'd0;
	localparam logic [1:0] DIR_FORWARD = 2'd1;
	localparam logic [1:0] DIR_REVERSE = 2'd2;

	localparam logic [2:0] REG_ENABLED = 3'd0;
	localparam logic [2:0] REG_SENSOR_MODE = 3'd1;
	localparam logic [2:0] REG_PULSE_EDGE = 3'd2;
	localparam logic [2:0] REG_QUAD_RES = 3'd3;
	localparam logic [2:0] REG_REVERSE = 3'd4;
	localparam logic [2:0] REG_DEBOUNCE = 3'd5;

	localparam logic [1:0] EDGE_RISING = 2'd0;
	localparam logic [1:0] EDGE_BOTH = 2'd2;
	localparam logic [1:0] RES_X4 = 2'd0;
	localparam logic [1:0] RES_X2 = 2'd1;

	localparam int QDEPTH = 2;

	// classified item passed from front to back
	typedef struct packed {
		logic resync;
		logic idle;
		logic [31:0] time_us;
		logic pin_a;
		logic pin_b;
	} item_t;

	typedef struct packed {
		logic [2:0] event_class;
		logic signed [31:0] position_count;
		logic [1:0] direction;
		logic [31:0] accepted_count;
		logic [31:0] invalid_count;
		logic [31:0] debounced_count;
		logic [31:0] last_interval_us;
		logic [31:0] min_interval_us;
		logic [31:0] max_interval_us;
		logic [31:0] interval_samples;
		logic [63:0] interval_sum_us;
		logic [63:0] jitter_sum_us;
	} result_t;

	// gray-code step: +1, -1, or 0 for no change / two-bit jump
	function automatic logic [1:0] gray_step(input logic [1:0] p, input logic [1:0] c);
		logic [3:0] idx;
		idx = {p, c};
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: gray_step = 2'b01;
			4'd2, 4'd4, 4'd11, 4'd13: gray_step = 2'b11;
			default: gray_step = 2'b00;
		endcase
	endfunction
endpackage

>>> design/qpd_if.sv
// ----------------------------------------------------------------------
// qpd channel interfaces
// valid/ready stream carrying input items, results and register writes
// ----------------------------------------------------------------------
interface qpd_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [31:0] time_us;
	logic pin_a;
	logic pin_b;
	modport source (output valid, action, time_us, pin_a, pin_b, input ready);
	modport sink (input valid, action, time_us, pin_a, pin_b, output ready);
endinterface

interface qpd_out_if;
	logic valid;
	logic ready;
	logic [2:0] event_class;
	logic signed [31:0] position_count;
	logic [1:0] direction;
	logic [31:0] accepted_count;
	logic [31:0] invalid_count;
	logic [31:0] debounced_count;
	logic [31:0] last_interval_us;
	logic [31:0] min_interval_us;
	logic [31:0] max_interval_us;
	logic [31:0] interval_samples;
	logic [63:0] interval_sum_us;
	logic [63:0] jitter_sum_us;
	modport source (output valid, event_class, position_count, direction, accepted_count,
		invalid_count, debounced_count, last_interval_us, min_interval_us,
		max_interval_us, interval_samples, interval_sum_us, jitter_sum_us, input ready);
	modport sink (input valid, event_class, position_count, direction, accepted_count,
		invalid_count, debounced_count, last_interval_us, min_interval_us,
		max_interval_us, interval_samples, interval_sum_us, jitter_sum_us, output ready);
endinterface

interface qpd_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/qpd_front.sv
// ----------------------------------------------------------------------
// qpd_front
// accepts items, tags resync and disabled events, feeds the queue
// ----------------------------------------------------------------------
module qpd_front (
	input logic arst_n,
	qpd_in_if.sink in_ch,
	input logic enabled,
	input logic q_full,
	output logic q_push,
	output qpd_pkg::item_t q_item
);
	import qpd_pkg::*;

	assign in_ch.ready = !q_full && arst_n;
	assign q_push = in_ch.valid && in_ch.ready;

	always_comb begin
		q_item.resync = in_ch.action;
		q_item.idle = !in_ch.action && !enabled;
		q_item.time_us = in_ch.time_us;
		q_item.pin_a = in_ch.pin_a;
		q_item.pin_b = in_ch.pin_b;
	end
endmodule

>>> design/qpd_queue.sv
// ----------------------------------------------------------------------
// qpd_queue
// two-entry fifo between the front and the back
// ----------------------------------------------------------------------
module qpd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input qpd_pkg::item_t din,
	output logic full,
	input logic pop,
	output logic empty,
	output qpd_pkg::item_t dout
);
	import qpd_pkg::*;

	item_t mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wr_q, rd_q;
	logic [$clog2(QDEPTH):0] cnt_q;

	assign full = (cnt_q == ($clog2(QDEPTH)+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
		end
	end
endmodule

>>> design/qpd_back.sv
// ----------------------------------------------------------------------
// qpd_back
// decodes events, updates counters and statistics, holds the result
// ----------------------------------------------------------------------
module qpd_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input qpd_pkg::item_t q_item,
	output logic q_pop,
	input logic sensor_mode,
	input logic [1:0] pulse_edge,
	input logic [1:0] quad_resolution,
	input logic reverse_direction,
	input logic [15:0] debounce_us,
	qpd_out_if.source out_ch
);
	import qpd_pkg::*;

	logic signed [31:0] step_q;
	logic prev_a_q, prev_b_q;
	logic [1:0] pqs_q, dir_q;
	logic [31:0] acc_q, inv_q, deb_q, last_t_q, last_iv_q, min_q, max_q, prev_iv_q, ivn_q;
	logic [63:0] ivsum_q, jsum_q;
	result_t res_q;
	logic vld_q;

	logic take, edge_ok, debounced, fwd, do_pins, do_quad_state, was_inv;
	logic [1:0] cur, st;
	logic [31:0] iv, jit;
	cls_t cls;

	assign q_pop = !q_empty && (!vld_q || out_ch.ready);
	assign cur = {q_item.pin_a, q_item.pin_b};
	assign st = gray_step(pqs_q, cur);
	assign iv = q_item.time_us - last_t_q;
	assign jit = (iv > prev_iv_q) ? iv - prev_iv_q : prev_iv_q - iv;

	always_comb begin
		take = 1'b0;
		fwd = 1'b1;
		do_pins = 1'b0;
		do_quad_state = 1'b0;
		was_inv = 1'b0;
		debounced = (debounce_us != '0) && (iv < {16'd0, debounce_us});
		edge_ok = 1'b0;
		cls = CLS_IDLE;
		if (!q_item.resync && !q_item.idle) begin
			if (debounced) begin
				cls = CLS_DEBOUNCED;
			end else if (!sensor_mode) begin
				do_pins = 1'b1;
				if (prev_a_q != q_item.pin_a) begin
					if (pulse_edge == EDGE_BOTH) edge_ok = 1'b1;
					else if (pulse_edge == EDGE_RISING) edge_ok = q_item.pin_a;
					else edge_ok = !q_item.pin_a;
				end
				take = edge_ok;
				cls = edge_ok ? CLS_ACCEPTED : CLS_NOT_COUNTED;
			end else if (cur == pqs_q) begin
				cls = CLS_NOT_COUNTED;
			end else if (st == 2'b00) begin
				do_pins = 1'b1;
				do_quad_state = 1'b1;
				was_inv = 1'b1;
				cls = CLS_INVALID;
			end else begin
				do_pins = 1'b1;
				do_quad_state = 1'b1;
				if (quad_resolution == RES_X4) edge_ok = 1'b1;
				else if (quad_resolution == RES_X2) edge_ok = pqs_q[1] != cur[1];
				else edge_ok = !pqs_q[1] && cur[1];
				take = edge_ok;
				fwd = (st == 2'b01) ^ reverse_direction;
				cls = edge_ok ? CLS_ACCEPTED : CLS_NOT_COUNTED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0; prev_a_q <= 1'b0; prev_b_q <= 1'b0; pqs_q <= '0; dir_q <= DIR_UNKNOWN;
			acc_q <= '0; inv_q <= '0; deb_q <= '0; last_t_q <= '0; last_iv_q <= '0;
			min_q <= '0; max_q <= '0; prev_iv_q <= '0; ivn_q <= '0;
			ivsum_q <= '0; jsum_q <= '0; vld_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) vld_q <= 1'b0;
			if (q_pop) begin
				vld_q <= 1'b1;
				if (q_item.resync) begin
					prev_a_q <= q_item.pin_a; prev_b_q <= q_item.pin_b; pqs_q <= cur;
					step_q <= '0; dir_q <= DIR_UNKNOWN; acc_q <= '0; inv_q <= '0;
					deb_q <= '0; last_t_q <= '0; last_iv_q <= '0; min_q <= '0;
					max_q <= '0; prev_iv_q <= '0; ivn_q <= '0; ivsum_q <= '0; jsum_q <= '0;
				end else begin
					if (cls == CLS_DEBOUNCED) deb_q <= deb_q + 1'b1;
					if (was_inv) inv_q <= inv_q + 1'b1;
					if (do_pins) begin
						prev_a_q <= q_item.pin_a; prev_b_q <= q_item.pin_b;
					end
					if (do_quad_state) pqs_q <= cur;
					if (take) begin
						step_q <= fwd ? step_q + 32'sd1 : step_q - 32'sd1;
						dir_q <= fwd ? DIR_FORWARD : DIR_REVERSE;
						acc_q <= acc_q + 1'b1;
						last_t_q <= q_item.time_us;
						if (last_t_q != '0) begin
							last_iv_q <= iv;
							if (min_q == '0 || iv < min_q) min_q <= iv;
							if (iv > max_q) max_q <= iv;
							ivsum_q <= ivsum_q + {32'd0, iv};
							ivn_q <= ivn_q + 1'b1;
							if (prev_iv_q != '0) jsum_q <= jsum_q + {32'd0, jit};
							prev_iv_q <= iv;
						end
					end
				end
			end
		end
	end

	// result register, filled from the post-update state and the class registered with it
	logic [2:0] cls_s1;
	always_ff @(posedge clk) begin
		if (q_pop) cls_s1 <= cls;
	end

	always_comb begin
		res_q.event_class = cls_s1;
		res_q.position_count = step_q;
		res_q.direction = dir_q;
		res_q.accepted_count = acc_q;
		res_q.invalid_count = inv_q;
		res_q.debounced_count = deb_q;
		res_q.last_interval_us = last_iv_q;
		res_q.min_interval_us = min_q;
		res_q.max_interval_us = max_q;
		res_q.interval_samples = ivn_q;
		res_q.interval_sum_us = ivsum_q;
		res_q.jitter_sum_us = jsum_q;
	end

	assign out_ch.valid = vld_q;
	assign out_ch.event_class = res_q.event_class;
	assign out_ch.position_count = res_q.position_count;
	assign out_ch.direction = res_q.direction;
	assign out_ch.accepted_count = res_q.accepted_count;
	assign out_ch.invalid_count = res_q.invalid_count;
	assign out_ch.debounced_count = res_q.debounced_count;
	assign out_ch.last_interval_us = res_q.last_interval_us;
	assign out_ch.min_interval_us = res_q.min_interval_us;
	assign out_ch.max_interval_us = res_q.max_interval_us;
	assign out_ch.interval_samples = res_q.interval_samples;
	assign out_ch.interval_sum_us = res_q.interval_sum_us;
	assign out_ch.jitter_sum_us = res_q.jitter_sum_us;
endmodule

>>> design/quadrature_pulse_decoder_stats_top.sv
// ----------------------------------------------------------------------
// quadrature_pulse_decoder_stats_top
// tachometer / quadrature decoder with edge interval statistics
// ----------------------------------------------------------------------
// one result per item; an item is taken every clock while results drain.
// an item passes through the two-entry queue, then through the state
// update in the back end, whose state registers double as the output
// register (the result shows the state after its item). the state update
// loop of the back end sets the rate at one item per clock while results
// drain. register writes are taken at any time and must only be made
// while the block is idle.
module quadrature_pulse_decoder_stats_top (
	input logic clk,
	input logic arst_n,
	qpd_in_if.sink in_ch,
	qpd_out_if.source out_ch,
	qpd_cfg_if.sink cfg
);
	import qpd_pkg::*;

	// configuration registers
	logic enabled_q, sensor_mode_q, reverse_q;
	logic [1:0] pulse_edge_q, quad_res_q;
	logic [15:0] debounce_q;

	// front to back queue
	item_t f_item, b_item;
	logic q_push, q_pop, q_full, q_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0; sensor_mode_q <= 1'b0; reverse_q <= 1'b0;
			pulse_edge_q <= '0; quad_res_q <= '0; debounce_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ENABLED: enabled_q <= cfg.data[0];
				REG_SENSOR_MODE: sensor_mode_q <= cfg.data[0];
				REG_PULSE_EDGE: pulse_edge_q <= cfg.data[1:0];
				REG_QUAD_RES: quad_res_q <= cfg.data[1:0];
				REG_REVERSE: reverse_q <= cfg.data[0];
				REG_DEBOUNCE: debounce_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// accept and tag items
	qpd_front u_front (
		.arst_n(arst_n), .in_ch(in_ch), .enabled(enabled_q),
		.q_full(q_full), .q_push(q_push), .q_item(f_item)
	);

	// decouples input transfers from result stalls
	qpd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(f_item), .full(q_full),
		.pop(q_pop), .empty(q_empty), .dout(b_item)
	);

	// decode, count and present the result
	qpd_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_item(b_item), .q_pop(q_pop),
		.sensor_mode(sensor_mode_q), .pulse_edge(pulse_edge_q),
		.quad_resolution(quad_res_q), .reverse_direction(reverse_q),
		.debounce_us(debounce_q), .out_ch(out_ch)
	);
endmodule

>>> design/qpd_checker.sv
// ----------------------------------------------------------------------
// qpd_checker
// port level checks on the decoder
// ----------------------------------------------------------------------
`include "quadrature_pulse_decoder_stats_top_macros.svh"
module qpd_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] event_class,
	input logic [1:0] direction,
	input logic [31:0] accepted_count
);
	import qpd_pkg::*;

	`QPD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`QPD_ASSERT_IMP(a_dir_code, out_valid, direction != 2'd3)
	`QPD_ASSERT_IMP(a_cls_code, out_valid,
		event_class == CLS_ACCEPTED || event_class == CLS_NOT_COUNTED ||
		event_class == CLS_DEBOUNCED || event_class == CLS_INVALID || event_class == CLS_IDLE)
	`QPD_ASSERT_IMP(a_acc_dir, out_valid && event_class == CLS_ACCEPTED,
		direction != DIR_UNKNOWN && accepted_count != '0)
endmodule

bind quadrature_pulse_decoder_stats_top qpd_checker u_qpd_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.event_class(out_ch.event_class), .direction(out_ch.direction),
	.accepted_count(out_ch.accepted_count)
);

>>> tb/tb_quadrature_pulse_decoder_stats_top.sv
// ----------------------------------------------------------------------
// tb_quadrature_pulse_decoder_stats_top
// self-checking bench: directed table then random encoder traffic over
// several register settings, each result checked against a local model
// ----------------------------------------------------------------------
module tb_quadrature_pulse_decoder_stats_top;
	timeunit 1ns;
	timeprecision 1ps;
	import qpd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 190;

	logic clk;
	logic arst_n;

	qpd_in_if in_ch ();
	qpd_out_if out_ch ();
	qpd_cfg_if cfg ();

	quadrature_pulse_decoder_stats_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// shadow registers
	bit cf_enabled, cf_mode, cf_reverse;
	bit [1:0] cf_edge, cf_res;
	bit [15:0] cf_debounce;

	// shadow decoder state
	bit [31:0] st_steps, st_accepted, st_invalid, st_debounced;
	bit st_a, st_b;
	bit [1:0] st_quad, st_dir, st_raw_dir;
	bit [31:0] st_last_edge, st_last_iv, st_min_iv, st_max_iv, st_prev_iv;
	bit [31:0] st_iv_count, st_jit_count;
	bit [63:0] st_iv_sum, st_jit_sum;

	result_t pending_results[$];
	int mismatches;
	int cycles;
	bit hold_req, hold_done;
	bit quiet;

	// gray-code step indexed by {prev, cur}; zero is no change or a jump
	function automatic int quad_delta(bit [1:0] p, bit [1:0] c);
		case ({p, c})
			4'd1, 4'd7, 4'd8, 4'd14: return 1;
			4'd2, 4'd4, 4'd11, 4'd13: return -1;
			default: return 0;
		endcase
	endfunction

	function automatic void clear_stats();
		st_steps = 0; st_dir = DIR_UNKNOWN; st_raw_dir = DIR_UNKNOWN;
		st_accepted = 0; st_invalid = 0; st_debounced = 0;
		st_last_edge = 0; st_last_iv = 0; st_min_iv = 0; st_max_iv = 0;
		st_prev_iv = 0; st_iv_count = 0; st_jit_count = 0;
		st_iv_sum = 0; st_jit_sum = 0;
	endfunction

	// interval bookkeeping for an accepted edge
	function automatic void log_edge(bit [31:0] now);
		bit [31:0] iv, jit;
		if (st_last_edge != 0) begin
			iv = now - st_last_edge;
			st_last_iv = iv;
			if (st_min_iv == 0 || iv < st_min_iv) st_min_iv = iv;
			if (iv > st_max_iv) st_max_iv = iv;
			st_iv_sum += 64'(iv);
			st_iv_count++;
			if (st_prev_iv != 0) begin
				jit = (iv > st_prev_iv) ? iv - st_prev_iv : st_prev_iv - iv;
				st_jit_sum += 64'(jit);
				st_jit_count++;
			end
			st_prev_iv = iv;
		end
		st_accepted++;
		st_last_edge = now;
	endfunction

	function automatic cls_t pin_event(bit [31:0] now, bit a, bit b);
		bit pa, ca, take;
		bit [1:0] cur, prv;
		int d;
		if (cf_debounce != 0 && (now - st_last_edge) < 32'(cf_debounce)) begin
			st_debounced++;
			return CLS_DEBOUNCED;
		end
		if (!cf_mode) begin
			pa = st_a;
			st_a = a; st_b = b;
			if (pa == a) take = 0;
			else if (cf_edge == EDGE_BOTH) take = 1;
			else if (cf_edge == EDGE_RISING) take = a;
			else take = !a;  // falling, and the unused code
			if (!take) return CLS_NOT_COUNTED;
			st_raw_dir = DIR_FORWARD;
			st_dir = DIR_FORWARD;
			log_edge(now);
			st_steps++;
			return CLS_ACCEPTED;
		end
		prv = st_quad;
		cur = {a, b};
		if (cur == prv) return CLS_NOT_COUNTED;
		d = quad_delta(prv, cur);
		if (d == 0) begin
			st_invalid++;
			st_quad = cur; st_a = a; st_b = b;
			return CLS_INVALID;
		end
		if (cf_res != RES_X4) begin
			pa = prv[1]; ca = cur[1];
			// x2 needs an A change, x1 (and the unused code) an A rise
			if (pa == ca || (cf_res != RES_X2 && !(!pa && ca))) begin
				st_quad = cur; st_a = a; st_b = b;
				return CLS_NOT_COUNTED;
			end
		end
		st_raw_dir = (d > 0) ? DIR_FORWARD : DIR_REVERSE;
		if (cf_reverse) d = -d;
		st_steps += 32'(d);
		st_dir = (d > 0) ? DIR_FORWARD : DIR_REVERSE;
		log_edge(now);
		st_quad = cur; st_a = a; st_b = b;
		return CLS_ACCEPTED;
	endfunction

	function automatic result_t decode_item(bit act, bit [31:0] now, bit a, bit b);
		result_t r;
		cls_t c;
		if (act) begin
			st_a = a; st_b = b; st_quad = {a, b};
			clear_stats();
			c = CLS_IDLE;
		end else if (!cf_enabled) begin
			c = CLS_IDLE;
		end else begin
			c = pin_event(now, a, b);
		end
		r.event_class = c;
		r.position_count = st_steps;
		r.direction = st_dir;
		r.accepted_count = st_accepted;
		r.invalid_count = st_invalid;
		r.debounced_count = st_debounced;
		r.last_interval_us = st_last_iv;
		r.min_interval_us = st_min_iv;
		r.max_interval_us = st_max_iv;
		r.interval_samples = st_iv_count;
		r.interval_sum_us = st_iv_sum;
		r.jitter_sum_us = st_jit_sum;
		return r;
	endfunction

	// clock and the single reset at start
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		in_ch.valid = 0; in_ch.action = 0; in_ch.time_us = 0;
		in_ch.pin_a = 0; in_ch.pin_b = 0;
		cfg.valid = 0; cfg.index = REG_ENABLED; cfg.data = 0;
		out_ch.ready = 1;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_quadrature_pulse_decoder_stats_top: errors");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				n = HOLD_CYCLES;
				hold_done = 1;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 13);
			end
			if (n > 0) begin
				out_ch.ready <= 0;
				repeat (n) @(posedge clk);
				out_ch.ready <= 1;
			end
			// wait for the transfer of one result
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	task automatic check_field(string name, logic [63:0] exp, logic [63:0] got, ref bit bad);
		if (exp !== got) begin
			bad = 1;
			if (mismatches < 10)
				$display("  %s: expected %h, got %h", name, exp, got);
		end
	endtask

	// compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		result_t exp;
		bit bad;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10) $display("unexpected result at cycle %0d", cycles);
				mismatches++;
			end else begin
				exp = pending_results.pop_front();
				bad = 0;
				check_field("event_class", exp.event_class, out_ch.event_class, bad);
				check_field("position_count", exp.position_count, out_ch.position_count, bad);
				check_field("direction", exp.direction, out_ch.direction, bad);
				check_field("accepted_count", exp.accepted_count, out_ch.accepted_count, bad);
				check_field("invalid_count", exp.invalid_count, out_ch.invalid_count, bad);
				check_field("debounced_count", exp.debounced_count,
					out_ch.debounced_count, bad);
				check_field("last_interval", exp.last_interval_us,
					out_ch.last_interval_us, bad);
				check_field("min_interval", exp.min_interval_us, out_ch.min_interval_us, bad);
				check_field("max_interval", exp.max_interval_us, out_ch.max_interval_us, bad);
				check_field("interval_samples", exp.interval_samples,
					out_ch.interval_samples, bad);
				check_field("interval_sum", exp.interval_sum_us, out_ch.interval_sum_us, bad);
				check_field("jitter_sum", exp.jitter_sum_us, out_ch.jitter_sum_us, bad);
				if (bad) mismatches++;
			end
		end
	end

	// wait for all results plus the pipeline depth
	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		case (idx)
			REG_ENABLED: cf_enabled = val[0];
			REG_SENSOR_MODE: cf_mode = val[0];
			REG_PULSE_EDGE: cf_edge = val[1:0];
			REG_QUAD_RES: cf_res = val[1:0];
			REG_REVERSE: cf_reverse = val[0];
			REG_DEBOUNCE: cf_debounce = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// one input transfer; the expectation is formed when it is taken
	task automatic send_item(bit act, bit [31:0] now, bit a, bit b,
		bit force_cls, cls_t cls);
		int gap;
		result_t r;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.action <= act;
		in_ch.time_us <= now;
		in_ch.pin_a <= a;
		in_ch.pin_b <= b;
		do @(posedge clk); while (!in_ch.ready);
		r = decode_item(act, now, a, b);
		if (force_cls) r.event_class = cls;
		pending_results.push_back(r);
	endtask

	typedef struct {
		bit is_cfg;
		logic [2:0] idx;
		logic [15:0] val;
		bit act;
		logic [31:0] t;
		bit a;
		bit b;
		bit has_cls;
		cls_t cls;
	} step_row_t;

	step_row_t directed[$];

	function automatic step_row_t reg_row(logic [2:0] idx, logic [15:0] val);
		step_row_t s;
		s = '{1, idx, val, 0, 0, 0, 0, 0, CLS_IDLE};
		return s;
	endfunction

	function automatic step_row_t ev_row(bit act, logic [31:0] t, bit a, bit b,
		bit has, cls_t c);
		step_row_t s;
		s = '{0, REG_ENABLED, 0, act, t, a, b, has, c};
		return s;
	endfunction

	initial begin
		bit [31:0] now;
		bit [1:0] qs;
		bit pa;
		int r, dmax;

		clear_stats();
		st_a = 0; st_b = 0; st_quad = 0;

		// directed table: class given where it is obvious
		directed = '{
			ev_row(0, 32'd5, 1, 0, 1, CLS_IDLE),             // disabled after reset
			reg_row(REG_ENABLED, 16'd1),
			ev_row(0, 32'd0, 1, 0, 1, CLS_ACCEPTED),         // edge at time zero
			ev_row(0, 32'd100, 0, 1, 1, CLS_NOT_COUNTED),
			ev_row(0, 32'd200, 1, 1, 1, CLS_ACCEPTED),
			ev_row(0, 32'd300, 1, 0, 1, CLS_NOT_COUNTED),
			reg_row(REG_PULSE_EDGE, 16'd3),                  // unused code acts as falling
			ev_row(0, 32'd400, 0, 0, 1, CLS_ACCEPTED),
			reg_row(REG_PULSE_EDGE, 16'(EDGE_BOTH)),
			ev_row(0, 32'hFFFF_FFF0, 1, 1, 0, CLS_IDLE),      // huge interval
			ev_row(0, 32'h0000_0010, 0, 0, 0, CLS_IDLE),      // wrapped interval
			reg_row(REG_DEBOUNCE, 16'hFFFF),
			ev_row(0, 32'h0000_0020, 1, 0, 1, CLS_DEBOUNCED),
			ev_row(1, 32'hFFFF_FFFF, 0, 0, 1, CLS_IDLE),      // resync
			reg_row(REG_DEBOUNCE, 16'd0),
			reg_row(REG_SENSOR_MODE, 16'd1),
			ev_row(0, 32'd10, 0, 1, 0, CLS_IDLE),
			ev_row(0, 32'd25, 1, 1, 0, CLS_IDLE),
			ev_row(0, 32'd40, 0, 0, 1, CLS_INVALID),          // two-bit jump
			ev_row(0, 32'd55, 0, 0, 1, CLS_NOT_COUNTED),
			ev_row(0, 32'd70, 0, 1, 0, CLS_IDLE),
			reg_row(REG_REVERSE, 16'd1),
			ev_row(0, 32'd90, 0, 0, 0, CLS_IDLE),
			reg_row(REG_QUAD_RES, 16'd3),                    // unused code acts as x1
			ev_row(0, 32'd110, 1, 0, 0, CLS_IDLE),
			ev_row(0, 32'd130, 1, 1, 1, CLS_NOT_COUNTED),
			reg_row(REG_QUAD_RES, 16'(RES_X2)),
			ev_row(0, 32'd150, 0, 1, 0, CLS_IDLE),
			ev_row(1, 32'd0, 1, 1, 1, CLS_IDLE)
		};

		@(posedge arst_n);
		@(posedge clk);
		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				// stop offering the last item before the block goes idle
				in_ch.valid <= 0;
				drain();
				write_reg(directed[i].idx, directed[i].val);
			end else begin
				send_item(directed[i].act, directed[i].t, directed[i].a, directed[i].b,
					directed[i].has_cls, directed[i].cls);
			end
		end
		in_ch.valid <= 0;

		// random phases, each with its own register setting
		now = 32'd1000;
		qs = 2'b11;
		pa = 1;
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			write_reg(REG_ENABLED, (p == 2) ? 16'd0 : 16'd1);
			write_reg(REG_SENSOR_MODE, 16'(p[0]));
			write_reg(REG_PULSE_EDGE, 16'($urandom_range(0, 3)));
			write_reg(REG_QUAD_RES, 16'((p == 1) ? 0 : $urandom_range(0, 3)));
			write_reg(REG_REVERSE, 16'($urandom_range(0, 1)));
			case (p % 4)
				0: write_reg(REG_DEBOUNCE, 16'd0);
				1: write_reg(REG_DEBOUNCE, 16'($urandom_range(1, 40)));
				2: write_reg(REG_DEBOUNCE, 16'hFFFF);
				default: write_reg(REG_DEBOUNCE, 16'($urandom));
			endcase
			dmax = (cf_debounce > 16'd200) ? 400 : 2 * cf_debounce + 60;
			quiet = (p == 3);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// fill the block while results are held back
				if (p == 5 && k == 20) begin
					quiet = 1;
					hold_req = 1;
				end
				if (p == 5 && k == 40) quiet = 0;
				r = $urandom_range(0, 99);
				if (r < 3) now = $urandom;
				else if (cf_debounce == 16'hFFFF && r < 30) now += 32'($urandom_range(65535, 70000));
				else now += 32'($urandom_range(0, dmax));
				r = $urandom_range(0, 99);
				if (r < 2) begin
					qs = 2'($urandom);
					pa = qs[1];
					send_item(1, $urandom, qs[1], qs[0], 0, CLS_IDLE);
				end else if (!cf_mode) begin
					if (r < 80) pa = !pa;
					send_item(0, now, pa, 1'($urandom_range(0, 1)), 0, CLS_IDLE);
				end else begin
					// mostly legal gray steps, some jumps and repeats
					if (r < 88) begin
						case ({qs, 1'($urandom_range(0, 1))})
							3'b000: qs = 2'b01; 3'b001: qs = 2'b10;
							3'b010: qs = 2'b11; 3'b011: qs = 2'b00;
							3'b110: qs = 2'b10; 3'b111: qs = 2'b01;
							3'b100: qs = 2'b00; default: qs = 2'b11;
						endcase
					end else if (r < 95) begin
						qs = ~qs;
					end
					send_item(0, now, qs[1], qs[0], 0, CLS_IDLE);
				end
			end
			in_ch.valid <= 0;
		end

		drain();
		if (mismatches == 0)
			$display("tb_quadrature_pulse_decoder_stats_top: clean");
		else
			$display("tb_quadrature_pulse_decoder_stats_top: errors");
		$finish;
	end
endmodule

>>> files.f
+incdir+design
design/qpd_pkg.sv
design/qpd_if.sv
design/qpd_front.sv
design/qpd_queue.sv
design/qpd_back.sv
design/quadrature_pulse_decoder_stats_top.sv
design/qpd_checker.sv
tb/tb_quadrature_pulse_decoder_stats_top.sv
